// File: src/ptcr_pkg.sv
package ptcr_pkg;

    localparam int PIXEL_FRAC_BITS_DEF = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_PITCH,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_CENTRE_OFFSET_X,
        CFG_CENTRE_OFFSET_Y,
        CFG_PRINCIPAL_DISTANCE,
        CFG_RADIAL_K1,
        CFG_RADIAL_K2
    } t_cfg_idx;

    localparam logic [15:0] RST_PIXEL_PITCH = 16'd367;
    localparam logic [12:0] RST_IMAGE_WIDTH = 13'd1280;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd1024;
    localparam logic signed [31:0] RST_CENTRE_OFFSET_X = 32'sd0;
    localparam logic signed [31:0] RST_CENTRE_OFFSET_Y = 32'sd0;
    localparam logic [31:0] RST_PRINCIPAL_DISTANCE = 32'd1048576;
    localparam logic signed [31:0] RST_RADIAL_K1 = 32'sd0;
    localparam logic signed [31:0] RST_RADIAL_K2 = 32'sd0;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic signed [31:0] ray_x;
        logic signed [31:0] ray_y;
        logic [30:0]        ray_z;
        logic               saturated;
    } t_ray_out;

endpackage

// File: src/pixel_to_camera_ray.sv
// Pipelined pixel to unit camera ray converter.
// Each accepted item produces a result on o_result, marked by o_strobe.
// Throughput: one item per cycle; busy stays low, set by the fully pipelined datapath with
// a 32-stage square root and three 31-stage restoring dividers.
// Reset is synchronous and active low; it clears all in-flight items and restores the
// configuration registers to their reset values. The receiver cannot stall the results.
module pixel_to_camera_ray #(
    parameter int PIXEL_FRAC_BITS = ptcr_pkg::PIXEL_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ptcr_pkg::t_pix_in                   i_item,
    input  logic                                i_cfg_we,
    input  logic [ptcr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ptcr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_strobe,
    output ptcr_pkg::t_ray_out                  o_result
);

    localparam int F = PIXEL_FRAC_BITS;
    localparam int T_W = 19 + F;
    localparam int NUM_W = 40 + F;
    localparam int SQ_STAGES = 32;
    localparam int DV_STAGES = 31;
    localparam int LATENCY = 13 + 1 + SQ_STAGES + 1 + DV_STAGES + 1;

    typedef struct packed {
        logic signed [31:0] v;
        logic               sat;
    } t_clip;

    typedef struct packed {
        logic [33:0]      rem;
        logic [31:0]      root;
        logic [63:0]      x;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             sat;
        logic             zero;
    } t_sq;

    typedef struct packed {
        logic [2:0][31:0] rem;
        logic [2:0][30:0] num;
        logic [2:0][30:0] q;
        logic [31:0]      n;
        logic [2:0]       neg;
        logic             sat;
        logic             zero;
    } t_dv;

    function automatic t_clip lat_clip(input logic signed [NUM_W-1:0] num);
        logic             neg;
        logic [NUM_W-1:0] mag;
        logic [NUM_W-1:0] rnd;
        t_clip            res;
        neg = num[NUM_W-1];
        mag = neg ? NUM_W'(-num) : NUM_W'(num);
        rnd = (mag + (NUM_W'(1) << F)) >> (F + 1);
        res.sat = 1'b0;
        if (neg) begin
            if ((|rnd[NUM_W-1:32]) || (rnd[31] && (|rnd[30:0]))) begin
                res.sat = 1'b1;
                res.v = 32'sh8000_0000;
            end else begin
                res.v = 32'(32'd0 - rnd[31:0]);
            end
        end else begin
            if (|rnd[NUM_W-1:31]) begin
                res.sat = 1'b1;
                res.v = 32'sh7fff_ffff;
            end else begin
                res.v = rnd[31:0];
            end
        end
        return res;
    endfunction

    function automatic logic signed [49:0] rshr16(input logic signed [64:0] p);
        logic        neg;
        logic [64:0] mag;
        logic [64:0] s;
        logic [49:0] rr;
        neg = p[64];
        mag = neg ? 65'(-p) : 65'(p);
        s = mag + 65'd32768;
        rr = {1'b0, s[64:16]};
        return neg ? 50'(50'd0 - rr) : rr;
    endfunction

    logic [15:0]        r_pitch;
    logic [12:0]        r_width;
    logic [12:0]        r_height;
    logic signed [31:0] r_offx;
    logic signed [31:0] r_offy;
    logic [31:0]        r_pd;
    logic signed [31:0] r_k1;
    logic signed [31:0] r_k2;

    logic [LATENCY-1:0] r_vld;

    logic [T_W-1:0]         tx;
    logic [T_W-1:0]         ty;
    logic signed [NUM_W-1:0] n1_xn;
    logic signed [NUM_W-1:0] n1_yn;
    logic signed [NUM_W-1:0] r1_xn;
    logic signed [NUM_W-1:0] r1_yn;

    t_clip n2_x;
    t_clip n2_y;
    logic signed [31:0] r2_x, r2_y;
    logic               r2_sat;

    logic [31:0]        ax, ay;
    logic signed [31:0] r3_x, r3_y;
    logic               r3_sat;
    logic [63:0]        r3_sqx, r3_sqy;

    logic [64:0]        sum_r2;
    logic signed [31:0] r4_x, r4_y;
    logic               r4_sat;
    logic [31:0]        r4_r2;

    logic signed [31:0] r5_x, r5_y;
    logic               r5_sat;
    logic [63:0]        r5_p4;
    logic signed [64:0] r5_pt1;

    logic [64:0]        sum_r4;
    logic signed [31:0] r6_x, r6_y;
    logic               r6_sat;
    logic [31:0]        r6_r4;
    logic signed [49:0] r6_t1;

    logic signed [31:0] r7_x, r7_y;
    logic               r7_sat;
    logic signed [64:0] r7_pt2;
    logic signed [49:0] r7_t1;

    logic signed [51:0] fw;
    logic signed [31:0] r8_x, r8_y;
    logic               r8_sat;
    logic signed [31:0] r8_f;

    logic signed [63:0] r9_px, r9_py;
    logic               r9_sat;

    logic [63:0]        abs_px, abs_py, rnd_px, rnd_py;
    logic [2:0][39:0]   r10_mag;
    logic [2:0]         r10_neg;
    logic               r10_sat;

    logic [39:0]        mx;
    logic [5:0]         msb;
    logic [2:0][39:0]   r11_mag;
    logic [2:0]         r11_neg;
    logic               r11_sat;
    logic               r11_zero;
    logic               r11_right;
    logic [4:0]         r11_sh;

    logic [40:0]        sh_t [3];
    logic [2:0][31:0]   r12_mag;
    logic [2:0]         r12_neg;
    logic               r12_sat;
    logic               r12_zero;

    logic [2:0][63:0]   r13_sq;
    logic [2:0][31:0]   r13_mag;
    logic [2:0]         r13_neg;
    logic               r13_sat;
    logic               r13_zero;

    t_sq r_sq [0:SQ_STAGES];
    t_sq n_sq [1:SQ_STAGES];
    t_dv r_dv [0:DV_STAGES];
    t_dv n_dv [1:DV_STAGES];
    t_dv n_dv0;

    ptcr_pkg::t_ray_out r_out;
    ptcr_pkg::t_ray_out n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= ptcr_pkg::RST_PIXEL_PITCH;
            r_width <= ptcr_pkg::RST_IMAGE_WIDTH;
            r_height <= ptcr_pkg::RST_IMAGE_HEIGHT;
            r_offx <= ptcr_pkg::RST_CENTRE_OFFSET_X;
            r_offy <= ptcr_pkg::RST_CENTRE_OFFSET_Y;
            r_pd <= ptcr_pkg::RST_PRINCIPAL_DISTANCE;
            r_k1 <= ptcr_pkg::RST_RADIAL_K1;
            r_k2 <= ptcr_pkg::RST_RADIAL_K2;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], start};
            if (i_cfg_we) begin
                case (ptcr_pkg::t_cfg_idx'(i_cfg_idx))
                    ptcr_pkg::CFG_PIXEL_PITCH: r_pitch <= i_cfg_data[15:0];
                    ptcr_pkg::CFG_IMAGE_WIDTH: r_width <= i_cfg_data[12:0];
                    ptcr_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[12:0];
                    ptcr_pkg::CFG_CENTRE_OFFSET_X: r_offx <= i_cfg_data[31:0];
                    ptcr_pkg::CFG_CENTRE_OFFSET_Y: r_offy <= i_cfg_data[31:0];
                    ptcr_pkg::CFG_PRINCIPAL_DISTANCE: r_pd <= i_cfg_data[31:0];
                    ptcr_pkg::CFG_RADIAL_K1: r_k1 <= i_cfg_data[31:0];
                    ptcr_pkg::CFG_RADIAL_K2: r_k2 <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        tx = T_W'({i_item.pixel_x, 1'b0}) - (T_W'(r_width) << F) + (T_W'(1) << F);
        ty = T_W'({i_item.pixel_y, 1'b0}) - (T_W'(r_height) << F) + (T_W'(1) << F);
        n1_xn = (NUM_W'(r_offx) <<< (F + 1))
              - $signed(NUM_W'(r_pitch)) * NUM_W'($signed(tx));
        n1_yn = (NUM_W'(r_offy) <<< (F + 1))
              - $signed(NUM_W'(r_pitch)) * NUM_W'($signed(ty));

        n2_x = lat_clip(r1_xn);
        n2_y = lat_clip(r1_yn);

        ax = r2_x[31] ? 32'(-r2_x) : 32'(r2_x);
        ay = r2_y[31] ? 32'(-r2_y) : 32'(r2_y);

        sum_r2 = 65'(r3_sqx) + 65'(r3_sqy) + 65'd32768;
        sum_r4 = 65'(r5_p4) + 65'd32768;

        fw = (52'sd1 <<< 24) - 52'(r7_t1) - 52'(rshr16(r7_pt2));

        abs_px = r9_px[63] ? 64'(-r9_px) : 64'(r9_px);
        abs_py = r9_py[63] ? 64'(-r9_py) : 64'(r9_py);
        rnd_px = abs_px + 64'd8388608;
        rnd_py = abs_py + 64'd8388608;

        mx = r10_mag[0];
        if (r10_mag[1] > mx) begin
            mx = r10_mag[1];
        end
        if (r10_mag[2] > mx) begin
            mx = r10_mag[2];
        end
        msb = '0;
        for (int i = 0; i < 40; i++) begin
            if (mx[i]) begin
                msb = 6'(i);
            end
        end

        for (int i = 0; i < 3; i++) begin
            if (r11_right) begin
                sh_t[i] = (41'(r11_mag[i]) + (41'(1) << (r11_sh - 5'd1))) >> r11_sh;
            end else begin
                sh_t[i] = 41'(r11_mag[i]) << r11_sh;
            end
        end
    end

    always_comb begin
        for (int k = 1; k <= SQ_STAGES; k++) begin
            logic [35:0] cur;
            logic [35:0] trial;
            cur = {r_sq[k-1].rem, r_sq[k-1].x[63:62]};
            trial = {2'b00, r_sq[k-1].root, 2'b01};
            n_sq[k] = r_sq[k-1];
            n_sq[k].x = {r_sq[k-1].x[61:0], 2'b00};
            if (cur >= trial) begin
                n_sq[k].rem = 34'(cur - trial);
                n_sq[k].root = {r_sq[k-1].root[30:0], 1'b1};
            end else begin
                n_sq[k].rem = cur[33:0];
                n_sq[k].root = {r_sq[k-1].root[30:0], 1'b0};
            end
        end

        n_dv0.n = r_sq[SQ_STAGES].root;
        n_dv0.neg = r_sq[SQ_STAGES].neg;
        n_dv0.sat = r_sq[SQ_STAGES].sat;
        n_dv0.zero = r_sq[SQ_STAGES].zero;
        n_dv0.q = '0;
        for (int i = 0; i < 3; i++) begin
            logic [61:0] numer;
            numer = {r_sq[SQ_STAGES].mag[i], 30'd0} + 62'(r_sq[SQ_STAGES].root >> 1);
            n_dv0.rem[i] = {1'b0, numer[61:31]};
            n_dv0.num[i] = numer[30:0];
        end

        for (int j = 1; j <= DV_STAGES; j++) begin
            n_dv[j] = r_dv[j-1];
            for (int i = 0; i < 3; i++) begin
                logic [32:0] cur;
                cur = {r_dv[j-1].rem[i], r_dv[j-1].num[i][30]};
                n_dv[j].num[i] = {r_dv[j-1].num[i][29:0], 1'b0};
                if (cur >= {1'b0, r_dv[j-1].n}) begin
                    n_dv[j].rem[i] = 32'(cur - {1'b0, r_dv[j-1].n});
                    n_dv[j].q[i] = {r_dv[j-1].q[i][29:0], 1'b1};
                end else begin
                    n_dv[j].rem[i] = cur[31:0];
                    n_dv[j].q[i] = {r_dv[j-1].q[i][29:0], 1'b0};
                end
            end
        end

        if (r_dv[DV_STAGES].zero) begin
            n_out.ray_x = '0;
            n_out.ray_y = '0;
            n_out.ray_z = '0;
        end else begin
            n_out.ray_x = r_dv[DV_STAGES].neg[0] ? 32'(32'd0 - {1'b0, r_dv[DV_STAGES].q[0]})
                                                 : {1'b0, r_dv[DV_STAGES].q[0]};
            n_out.ray_y = r_dv[DV_STAGES].neg[1] ? 32'(32'd0 - {1'b0, r_dv[DV_STAGES].q[1]})
                                                 : {1'b0, r_dv[DV_STAGES].q[1]};
            n_out.ray_z = r_dv[DV_STAGES].q[2];
        end
        n_out.saturated = r_dv[DV_STAGES].sat | r_dv[DV_STAGES].zero;
    end

    always_ff @(posedge i_clk) begin
        r1_xn <= n1_xn;
        r1_yn <= n1_yn;

        r2_x <= n2_x.v;
        r2_y <= n2_y.v;
        r2_sat <= n2_x.sat | n2_y.sat;

        r3_x <= r2_x;
        r3_y <= r2_y;
        r3_sat <= r2_sat;
        r3_sqx <= 64'(ax) * 64'(ax);
        r3_sqy <= 64'(ay) * 64'(ay);

        r4_x <= r3_x;
        r4_y <= r3_y;
        if (|sum_r2[64:48]) begin
            r4_r2 <= 32'hffff_ffff;
            r4_sat <= 1'b1;
        end else begin
            r4_r2 <= sum_r2[47:16];
            r4_sat <= r3_sat;
        end

        r5_x <= r4_x;
        r5_y <= r4_y;
        r5_sat <= r4_sat;
        r5_p4 <= 64'(r4_r2) * 64'(r4_r2);
        r5_pt1 <= $signed(65'(r_k1)) * $signed({33'd0, r4_r2});

        r6_x <= r5_x;
        r6_y <= r5_y;
        r6_t1 <= rshr16(r5_pt1);
        if (|sum_r4[64:48]) begin
            r6_r4 <= 32'hffff_ffff;
            r6_sat <= 1'b1;
        end else begin
            r6_r4 <= sum_r4[47:16];
            r6_sat <= r5_sat;
        end

        r7_x <= r6_x;
        r7_y <= r6_y;
        r7_sat <= r6_sat;
        r7_t1 <= r6_t1;
        r7_pt2 <= $signed(65'(r_k2)) * $signed({33'd0, r6_r4});

        r8_x <= r7_x;
        r8_y <= r7_y;
        if ((&fw[51:31]) || !(|fw[51:31])) begin
            r8_f <= fw[31:0];
            r8_sat <= r7_sat;
        end else begin
            r8_f <= fw[51] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            r8_sat <= 1'b1;
        end

        r9_px <= 64'(r8_x) * 64'(r8_f);
        r9_py <= 64'(r8_y) * 64'(r8_f);
        r9_sat <= r8_sat;

        r10_mag[0] <= rnd_px[63:24];
        r10_mag[1] <= rnd_py[63:24];
        r10_mag[2] <= 40'(r_pd);
        r10_neg[0] <= r9_px[63] && (|rnd_px[63:24]);
        r10_neg[1] <= r9_py[63] && (|rnd_py[63:24]);
        r10_neg[2] <= 1'b0;
        r10_sat <= r9_sat;

        r11_mag <= r10_mag;
        r11_neg <= r10_neg;
        r11_sat <= r10_sat;
        r11_zero <= (mx == '0);
        r11_right <= (msb >= 6'd31);
        r11_sh <= (msb >= 6'd31) ? 5'(msb - 6'd30) : 5'(6'd30 - msb);

        for (int i = 0; i < 3; i++) begin
            r12_mag[i] <= sh_t[i][31:0];
        end
        r12_neg <= r11_neg;
        r12_sat <= r11_sat;
        r12_zero <= r11_zero;

        for (int i = 0; i < 3; i++) begin
            r13_sq[i] <= 64'(r12_mag[i]) * 64'(r12_mag[i]);
        end
        r13_mag <= r12_mag;
        r13_neg <= r12_neg;
        r13_sat <= r12_sat;
        r13_zero <= r12_zero;

        r_sq[0].rem <= '0;
        r_sq[0].root <= '0;
        r_sq[0].x <= r13_sq[0] + r13_sq[1] + r13_sq[2];
        r_sq[0].mag <= r13_mag;
        r_sq[0].neg <= r13_neg;
        r_sq[0].sat <= r13_sat;
        r_sq[0].zero <= r13_zero;
        for (int k = 1; k <= SQ_STAGES; k++) begin
            r_sq[k] <= n_sq[k];
        end

        r_dv[0] <= n_dv0;
        for (int j = 1; j <= DV_STAGES; j++) begin
            r_dv[j] <= n_dv[j];
        end

        r_out <= n_out;
    end

    assign busy = 1'b0;
    assign o_strobe = r_vld[LATENCY-1];
    assign o_result = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted item did not produce a result on time");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("result strobe without a matching accepted item");

    a_zero_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.ray_x == '0 && o_result.ray_y == '0 && o_result.ray_z == '0)
        |-> o_result.saturated)
        else $error("zero ray without saturation flag");

    a_z_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.ray_z <= 31'h4000_0000))
        else $error("ray z component above unit length");

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    ptcr_pkg::t_pix_in               i_item;
    logic                            i_cfg_we;
    logic [ptcr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ptcr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            o_strobe;
    ptcr_pkg::t_ray_out              o_result;

    pixel_to_camera_ray i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_result(o_result)
    );

    longint unsigned pitch_q, width_q, height_q, focal_q;
    longint          offs_x_q, offs_y_q, k1_q, k2_q;

    ptcr_pkg::t_ray_out expected_rays[$];
    int       errors = 0;
    int       rays_checked = 0;
    int       items_sent;
    int       sat_seen = 0;
    int       cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d rays outstanding", $time, expected_rays.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint round_shift(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip_s32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint unsigned clip_u32(longint unsigned v, inout bit sat);
        if (v > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            return 64'hFFFF_FFFF;
        end
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint lateral_mm(longint unsigned pix, longint unsigned size,
                                          longint offs, inout bit sat);
        longint t;
        longint num;
        t = 2 * longint'(pix) - longint'(size) * 16 + 16;
        num = offs * 32 - longint'(pitch_q) * t;
        return clip_s32(round_shift(num, 5), sat);
    endfunction

    function automatic ptcr_pkg::t_ray_out camera_ray(ptcr_pkg::t_pix_in p);
        bit                 sat;
        longint             x, y, t1, t2, f;
        longint             v[3];
        longint unsigned    ax, ay, r2, r4, m, n;
        longint unsigned    mag[3];
        longint unsigned    q[3];
        bit                 neg[3];
        int                 s;
        ptcr_pkg::t_ray_out r;
        sat = 1'b0;
        x = lateral_mm(64'(p.pixel_x), width_q, offs_x_q, sat);
        y = lateral_mm(64'(p.pixel_y), height_q, offs_y_q, sat);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        r2 = clip_u32((ax * ax + ay * ay + (64'd1 << 15)) >> 16, sat);
        r4 = clip_u32((r2 * r2 + (64'd1 << 15)) >> 16, sat);
        t1 = round_shift(k1_q * longint'(r2), 16);
        t2 = round_shift(k2_q * longint'(r4), 16);
        f = clip_s32((64'sd1 << 24) - t1 - t2, sat);
        v[0] = round_shift(x * f, 24);
        v[1] = round_shift(y * f, 24);
        v[2] = longint'(focal_q);
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
            q[i] = 0;
        end
        if (m == 0) begin
            sat = 1'b1;
        end else begin
            s = 0;
            if (m >= (64'd1 << 31)) begin
                while ((m >> s) >= (64'd1 << 31)) s++;
                for (int i = 0; i < 3; i++) mag[i] = (mag[i] + (64'd1 << (s - 1))) >> s;
            end else begin
                while (m < (64'd1 << 30)) begin
                    m = m << 1;
                    s++;
                end
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << s;
            end
            n = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
            for (int i = 0; i < 3; i++) q[i] = (mag[i] * (64'd1 << 30) + n / 2) / n;
        end
        r.ray_x = neg[0] ? -q[0][31:0] : q[0][31:0];
        r.ray_y = neg[1] ? -q[1][31:0] : q[1][31:0];
        r.ray_z = q[2][30:0];
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (o_strobe) begin
            if (expected_rays.size() == 0) begin
                $display("%0t unexpected ray: expected none actual %h", $time, o_result);
                errors++;
            end else begin
                ptcr_pkg::t_ray_out e;
                e = expected_rays.pop_front();
                rays_checked++;
                if (e.saturated) sat_seen++;
                if (o_result.ray_x !== e.ray_x)
                    $display("%0t ray_x mismatch: expected %0d actual %0d", $time, e.ray_x,
                             o_result.ray_x);
                if (o_result.ray_y !== e.ray_y)
                    $display("%0t ray_y mismatch: expected %0d actual %0d", $time, e.ray_y,
                             o_result.ray_y);
                if (o_result.ray_z !== e.ray_z)
                    $display("%0t ray_z mismatch: expected %0d actual %0d", $time, e.ray_z,
                             o_result.ray_z);
                if (o_result.saturated !== e.saturated)
                    $display("%0t saturated mismatch: expected %0b actual %0b", $time,
                             e.saturated, o_result.saturated);
                if (o_result !== e) errors++;
            end
        end
    end

    task automatic write_reg(ptcr_pkg::t_cfg_idx idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            ptcr_pkg::CFG_PIXEL_PITCH:        pitch_q = 64'(data[15:0]);
            ptcr_pkg::CFG_IMAGE_WIDTH:        width_q = 64'(data[12:0]);
            ptcr_pkg::CFG_IMAGE_HEIGHT:       height_q = 64'(data[12:0]);
            ptcr_pkg::CFG_CENTRE_OFFSET_X:    offs_x_q = longint'(signed'(data));
            ptcr_pkg::CFG_CENTRE_OFFSET_Y:    offs_y_q = longint'(signed'(data));
            ptcr_pkg::CFG_PRINCIPAL_DISTANCE: focal_q = 64'(data);
            ptcr_pkg::CFG_RADIAL_K1:          k1_q = longint'(signed'(data));
            ptcr_pkg::CFG_RADIAL_K2:          k2_q = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_rays.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [15:0] px, logic [15:0] py);
        ptcr_pkg::t_pix_in p;
        p.pixel_x = px;
        p.pixel_y = py;
        start <= 1'b1;
        i_item <= p;
        do @(posedge i_clk); while (busy);
        expected_rays.push_back(camera_ray(p));
        items_sent++;
    endtask

    task automatic random_gap();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        len = (sel < 60) ? 0 : (sel < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (len > 0) begin
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    task automatic set_config(logic [15:0] pp, logic [12:0] w, logic [12:0] h,
                              logic [31:0] ox, logic [31:0] oy, logic [31:0] pd,
                              logic [31:0] k1, logic [31:0] k2);
        wait_drained();
        write_reg(ptcr_pkg::CFG_PIXEL_PITCH, 32'(pp));
        write_reg(ptcr_pkg::CFG_IMAGE_WIDTH, 32'(w));
        write_reg(ptcr_pkg::CFG_IMAGE_HEIGHT, 32'(h));
        write_reg(ptcr_pkg::CFG_CENTRE_OFFSET_X, ox);
        write_reg(ptcr_pkg::CFG_CENTRE_OFFSET_Y, oy);
        write_reg(ptcr_pkg::CFG_PRINCIPAL_DISTANCE, pd);
        write_reg(ptcr_pkg::CFG_RADIAL_K1, k1);
        write_reg(ptcr_pkg::CFG_RADIAL_K2, k2);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        send_pixel(16'd0, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0);
        send_pixel(16'd10232, 16'd8184);
        send_pixel(16'hAAAA, 16'h5555);
    endtask

    task automatic test_extreme_config();
        set_config(16'd0, 13'd1280, 13'd1024, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_pixel(16'd100, 16'd200);
        set_config(16'hFFFF, 13'd8191, 13'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'hFFFF, 16'hFFFF);
        set_config(16'hFFFF, 13'd1, 13'd4096, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1,
                   32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(16'd0, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0);
        set_config(16'd367, 13'd1280, 13'd1024, 32'd0, 32'd0, 32'd1048576,
                   32'd300000, 32'hFFFF_0000);
        send_pixel(16'd0, 16'd0);
        send_pixel(16'd10232, 16'd8184);
        send_pixel(16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_random_phase(int count, bit wild);
        if (wild)
            set_config(16'($urandom), 13'($urandom), 13'($urandom), $urandom, $urandom,
                       $urandom, $urandom, $urandom);
        else
            set_config(16'($urandom_range(100, 2000)), 13'($urandom_range(1, 4096)),
                       13'($urandom_range(1, 4096)),
                       32'($urandom_range(0, 2 ** 21) - 2 ** 20),
                       32'($urandom_range(0, 2 ** 21) - 2 ** 20),
                       32'($urandom_range(2 ** 18, 2 ** 26)),
                       32'($urandom_range(0, 2 ** 22) - 2 ** 21),
                       32'($urandom_range(0, 2 ** 18) - 2 ** 17));
        repeat (count) begin
            send_pixel(16'($urandom), 16'($urandom));
            random_gap();
        end
    endtask

    initial begin
        items_sent = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        pitch_q = 64'(ptcr_pkg::RST_PIXEL_PITCH);
        width_q = 64'(ptcr_pkg::RST_IMAGE_WIDTH);
        height_q = 64'(ptcr_pkg::RST_IMAGE_HEIGHT);
        offs_x_q = 64'(ptcr_pkg::RST_CENTRE_OFFSET_X);
        offs_y_q = 64'(ptcr_pkg::RST_CENTRE_OFFSET_Y);
        focal_q = 64'(ptcr_pkg::RST_PRINCIPAL_DISTANCE);
        k1_q = 64'(ptcr_pkg::RST_RADIAL_K1);
        k2_q = 64'(ptcr_pkg::RST_RADIAL_K2);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extreme_config();
        for (int ph = 0; ph < 10; ph++) test_random_phase(95, ph % 3 == 2);
        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("Sent %0d pixel items over 14 register settings, %0d rays checked.",
                 items_sent, rays_checked);
        $display("Saturated rays seen: %0d, failures: %0d.", sat_seen, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
